// File: rtl/core/vse_pkg.sv
// vse_pkg: shared types, widths and codes of the vorticity stencil engine
// no dependencies; used by the front, queue, back and top of the engine by scoped names
package vse_pkg;

    // sample and window geometry
    localparam int SAMPLE_W   = 16;
    localparam int WIN        = 5;
    localparam int LINES      = 4;
    localparam int LINE_DEPTH = 1024;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    // field widths
    localparam int COORD_W = 10;
    localparam int DIM_W   = 11;
    localparam int MODE_W  = 2;
    localparam int SCALE_W = 10;
    localparam int DIFF_W  = 21;
    localparam int PROD_W  = 32;
    localparam int NUM_W   = 33;
    localparam int CURL_W  = 32;

    // grid size limits
    localparam logic [DIM_W-1:0] DIM_MIN = 11'd5;
    localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // curl modes
    localparam logic [MODE_W-1:0] MODE_CENTRAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOKES  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LSQ     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RICH    = 2'd3;

    // reciprocals for exact 32-bit unsigned division by 5 and 3
    localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;
    localparam int SHIFT_5 = 34;
    localparam int SHIFT_3 = 33;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } cfg_t;

    // one curl job: numerator is ma*da - mb*db
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [SCALE_W-1:0]       ma;
        logic signed [DIFF_W-1:0] da;
        logic [SCALE_W-1:0]       mb;
        logic signed [DIFF_W-1:0] db;
        logic [COORD_W-1:0]       row;
        logic [COORD_W-1:0]       col;
    } job_t;

    function automatic logic signed [DIFF_W-1:0] sext(input logic signed [SAMPLE_W-1:0] v);
        sext = DIFF_W'(v);
    endfunction

endpackage

// File: rtl/core/vse_ram.sv
// vse_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module vse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/vse_front.sv
// vse_front: accepts samples, keeps line rams and the 5x5 window, tracks position
// and builds curl jobs; depends on vse_pkg and vse_ram
module vse_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  vse_pkg::cfg_t                cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [2*vse_pkg::SAMPLE_W-1:0] s_tdata,   // x_comp, y_comp
    output logic                         job_push,
    output vse_pkg::job_t                job,
    input  logic                         queue_full
);

    localparam logic [1:0] FS_IDLE  = 2'd0;
    localparam logic [1:0] FS_SHIFT = 2'd1;
    localparam logic [1:0] FS_PUSH  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [vse_pkg::COORD_W-1:0] row_reg, row_next, col_reg, col_next;
    logic [vse_pkg::COORD_W-1:0] orow_reg, orow_next, ocol_reg, ocol_next;
    logic emit_reg, emit_next;
    logic signed [vse_pkg::SAMPLE_W-1:0] xin_reg, yin_reg;
    logic signed [vse_pkg::SAMPLE_W-1:0] wx_reg [vse_pkg::WIN][vse_pkg::WIN];
    logic signed [vse_pkg::SAMPLE_W-1:0] wy_reg [vse_pkg::WIN][vse_pkg::WIN];
    logic [2*vse_pkg::SAMPLE_W-1:0] rd [vse_pkg::LINES];
    logic [vse_pkg::LINES-1:0] line_we;
    logic accept;
    logic [vse_pkg::DIM_W-1:0] w_clamp, h_clamp;
    logic [vse_pkg::DIM_W-1:0] row_ext, col_ext;
    logic [2:0] ctr2;
    logic [1:0] ctr;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == FS_IDLE);

    // grid size clamped to the supported range
    always_comb begin
        w_clamp = cfg.width;
        if (cfg.width < vse_pkg::DIM_MIN) w_clamp = vse_pkg::DIM_MIN;
        else if (cfg.width > vse_pkg::DIM_MAX) w_clamp = vse_pkg::DIM_MAX;
        h_clamp = cfg.height;
        if (cfg.height < vse_pkg::DIM_MIN) h_clamp = vse_pkg::DIM_MIN;
        else if (cfg.height > vse_pkg::DIM_MAX) h_clamp = vse_pkg::DIM_MAX;
    end

    // one line ram per row slot, x in low half and y in high half
    for (genvar s = 0; s < vse_pkg::LINES; s++) begin : g_line
        assign line_we[s] = (state_reg == FS_SHIFT) && (row_reg[1:0] == 2'(s));
        vse_ram #(
            .WIDTH(2*vse_pkg::SAMPLE_W),
            .DEPTH(vse_pkg::LINE_DEPTH)
        ) u_line (
            .aclk  (aclk),
            .we    (line_we[s]),
            .waddr (col_reg),
            .wdata ({yin_reg, xin_reg}),
            .re    (accept),
            .raddr (s_tready ? col_reg : col_reg),
            .rdata (rd[s])
        );
    end

    // sample latch
    always_ff @(posedge aclk) begin
        if (accept) begin
            xin_reg <= s_tdata[vse_pkg::SAMPLE_W-1:0];
            yin_reg <= s_tdata[2*vse_pkg::SAMPLE_W-1:vse_pkg::SAMPLE_W];
        end
    end

    // window shift with the line rams feeding the older rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < vse_pkg::WIN; d++) begin
                for (int e = 0; e < vse_pkg::WIN; e++) begin
                    wx_reg[d][e] <= '0;
                    wy_reg[d][e] <= '0;
                end
            end
        end else if (state_reg == FS_SHIFT) begin
            for (int d = 0; d < vse_pkg::WIN; d++) begin
                for (int e = 1; e < vse_pkg::WIN; e++) begin
                    wx_reg[d][e] <= wx_reg[d][e-1];
                    wy_reg[d][e] <= wy_reg[d][e-1];
                end
            end
            for (int d = 1; d < vse_pkg::WIN; d++) begin
                wx_reg[d][0] <= rd[2'(row_reg[1:0] - 2'(d))][vse_pkg::SAMPLE_W-1:0];
                wy_reg[d][0] <= rd[2'(row_reg[1:0] - 2'(d))][2*vse_pkg::SAMPLE_W-1:vse_pkg::SAMPLE_W];
            end
            wx_reg[0][0] <= xin_reg;
            wy_reg[0][0] <= yin_reg;
        end
    end

    // position, emission check and state sequencing
    assign row_ext = {1'b0, row_reg};
    assign col_ext = {1'b0, col_reg};
    assign ctr     = (cfg.mode == vse_pkg::MODE_CENTRAL || cfg.mode == vse_pkg::MODE_STOKES)
                     ? 2'd1 : 2'd2;
    assign ctr2    = {ctr, 1'b0};

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        emit_next  = emit_reg;
        job_push   = 1'b0;
        unique case (state_reg)
            FS_IDLE: begin
                if (accept) state_next = FS_SHIFT;
            end
            FS_SHIFT: begin
                emit_next = (row_ext >= 11'(ctr2)) && (col_ext >= 11'(ctr2))
                            && (row_ext < h_clamp) && (col_ext < w_clamp);
                orow_next = row_reg - 10'(ctr);
                ocol_next = col_reg - 10'(ctr);
                if (col_ext + 11'd1 >= w_clamp) begin
                    col_next = '0;
                    row_next = (row_ext + 11'd1 >= h_clamp) ? '0 : row_reg + 10'd1;
                end else begin
                    col_next = col_reg + 10'd1;
                end
                state_next = FS_PUSH;
            end
            FS_PUSH: begin
                if (!emit_reg) begin
                    state_next = FS_IDLE;
                end else if (!queue_full) begin
                    job_push   = 1'b1;
                    state_next = FS_IDLE;
                end
            end
            default: state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            emit_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge aclk) begin
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
    end

    // stencil differences from the window, per mode
    always_comb begin
        logic [vse_pkg::SCALE_W-1:0] nx, ny;
        nx = 10'(w_clamp - 11'd2);
        ny = 10'(h_clamp - 11'd2);
        job      = '0;
        job.mode = cfg.mode;
        job.row  = orow_reg;
        job.col  = ocol_reg;
        unique case (cfg.mode)
            vse_pkg::MODE_CENTRAL: begin
                job.ma = ny;
                job.da = vse_pkg::sext(wy_reg[1][0]) - vse_pkg::sext(wy_reg[1][2]);
                job.mb = nx;
                job.db = vse_pkg::sext(wx_reg[0][1]) - vse_pkg::sext(wx_reg[2][1]);
            end
            vse_pkg::MODE_STOKES: begin
                job.ma = ny;
                job.da = vse_pkg::sext(wx_reg[2][2]) + (vse_pkg::sext(wx_reg[1][2]) <<< 1)
                       + vse_pkg::sext(wx_reg[0][2]) - vse_pkg::sext(wx_reg[0][0])
                       - (vse_pkg::sext(wx_reg[1][0]) <<< 1) - vse_pkg::sext(wx_reg[2][0]);
                job.mb = nx;
                job.db = vse_pkg::sext(wy_reg[2][0]) + (vse_pkg::sext(wy_reg[2][1]) <<< 1)
                       + vse_pkg::sext(wy_reg[2][2]) - vse_pkg::sext(wy_reg[0][2])
                       - (vse_pkg::sext(wy_reg[0][1]) <<< 1) - vse_pkg::sext(wy_reg[0][0]);
            end
            vse_pkg::MODE_LSQ: begin
                job.ma = nx;
                job.da = (vse_pkg::sext(wx_reg[0][2]) <<< 1) + vse_pkg::sext(wx_reg[1][2])
                       - vse_pkg::sext(wx_reg[3][2]) - (vse_pkg::sext(wx_reg[4][2]) <<< 1);
                job.mb = ny;
                job.db = (vse_pkg::sext(wy_reg[2][0]) <<< 1) + vse_pkg::sext(wy_reg[2][1])
                       - vse_pkg::sext(wy_reg[2][3]) - (vse_pkg::sext(wy_reg[2][4]) <<< 1);
            end
            vse_pkg::MODE_RICH: begin
                job.ma = nx;
                job.da = vse_pkg::sext(wx_reg[4][2]) - vse_pkg::sext(wx_reg[0][2])
                       + ((vse_pkg::sext(wx_reg[1][2]) - vse_pkg::sext(wx_reg[3][2])) <<< 3);
                job.mb = ny;
                job.db = vse_pkg::sext(wy_reg[2][4]) - vse_pkg::sext(wy_reg[2][0])
                       + ((vse_pkg::sext(wy_reg[2][1]) - vse_pkg::sext(wy_reg[2][3])) <<< 3);
            end
            default: job.mode = cfg.mode;
        endcase
    end

endmodule

// File: rtl/core/vse_queue.sv
// vse_queue: short job queue between the stencil front and the arithmetic back
// depends on vse_pkg
module vse_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  vse_pkg::job_t push_job,
    input  logic          pop,
    output vse_pkg::job_t head,
    output logic          full,
    output logic          empty
);

    vse_pkg::job_t entry_reg [vse_pkg::QUEUE_DEPTH];
    logic [vse_pkg::QUEUE_AW-1:0] wptr_reg, rptr_reg;
    logic [vse_pkg::QUEUE_AW:0]   count_reg;

    assign full  = (count_reg == (vse_pkg::QUEUE_AW+1)'(vse_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (vse_pkg::QUEUE_AW+1)'(push)
                         - (vse_pkg::QUEUE_AW+1)'(pop);
        end
    end

endmodule

// File: rtl/core/vse_back.sv
// vse_back: scales, divides with rounding and saturates one curl job at a time
// depends on vse_pkg
module vse_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                queue_empty,
    input  vse_pkg::job_t       head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [vse_pkg::CURL_W-1:0]  curl_value,
    output logic [vse_pkg::COORD_W-1:0] cell_row,
    output logic [vse_pkg::COORD_W-1:0] cell_col
);

    localparam logic [2:0] BS_IDLE = 3'd0;
    localparam logic [2:0] BS_MUL  = 3'd1;
    localparam logic [2:0] BS_SUM  = 3'd2;
    localparam logic [2:0] BS_DIV  = 3'd3;
    localparam logic [2:0] BS_FIN  = 3'd4;
    localparam logic [2:0] BS_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    vse_pkg::job_t job_reg;
    logic signed [vse_pkg::PROD_W-1:0] pa_reg, pb_reg;
    logic neg_reg;
    logic [31:0] x_reg;
    logic [63:0] prod_reg;
    logic [vse_pkg::CURL_W-1:0] curl_reg;

    logic signed [vse_pkg::NUM_W-1:0] num;
    logic [vse_pkg::NUM_W-1:0] mag, biased;
    logic [31:0] quot;
    logic signed [vse_pkg::NUM_W-1:0] sval;

    assign pop        = (state_reg == BS_IDLE) && !queue_empty;
    assign m_tvalid   = (state_reg == BS_OUT);
    assign curl_value = curl_reg;
    assign cell_row   = job_reg.row;
    assign cell_col   = job_reg.col;

    // sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE: if (!queue_empty) state_next = BS_MUL;
            BS_MUL:  state_next = BS_SUM;
            BS_SUM:  state_next = BS_DIV;
            BS_DIV:  state_next = BS_FIN;
            BS_FIN:  state_next = BS_OUT;
            BS_OUT:  if (m_tready) state_next = BS_IDLE;
            default: state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= BS_IDLE;
        else          state_reg <= state_next;
    end

    // numerator magnitude with rounding bias, then pre-shift to an odd divisor
    always_comb begin
        num    = vse_pkg::NUM_W'(pa_reg) - vse_pkg::NUM_W'(pb_reg);
        mag    = num[vse_pkg::NUM_W-1] ? vse_pkg::NUM_W'(-num) : vse_pkg::NUM_W'(num);
        biased = mag;
        unique case (job_reg.mode)
            vse_pkg::MODE_CENTRAL: biased = mag + 33'd1;
            vse_pkg::MODE_STOKES:  biased = mag + 33'd4;
            vse_pkg::MODE_LSQ:     biased = mag + 33'd5;
            vse_pkg::MODE_RICH:    biased = mag + 33'd6;
            default:               biased = mag;
        endcase
    end

    // final quotient, sign and saturation
    always_comb begin
        unique case (job_reg.mode)
            vse_pkg::MODE_LSQ:  quot = 32'(prod_reg >> vse_pkg::SHIFT_5);
            vse_pkg::MODE_RICH: quot = 32'(prod_reg >> vse_pkg::SHIFT_3);
            default:            quot = x_reg;
        endcase
        sval = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BS_IDLE: if (!queue_empty) job_reg <= head;
            BS_MUL: begin
                pa_reg <= $signed({1'b0, job_reg.ma}) * job_reg.da;
                pb_reg <= $signed({1'b0, job_reg.mb}) * job_reg.db;
            end
            BS_SUM: begin
                neg_reg <= num[vse_pkg::NUM_W-1];
                unique case (job_reg.mode)
                    vse_pkg::MODE_CENTRAL: x_reg <= 32'(biased >> 1);
                    vse_pkg::MODE_STOKES:  x_reg <= 32'(biased >> 3);
                    vse_pkg::MODE_LSQ:     x_reg <= 32'(biased >> 1);
                    vse_pkg::MODE_RICH:    x_reg <= 32'(biased >> 2);
                    default:               x_reg <= 32'(biased);
                endcase
            end
            BS_DIV: begin
                prod_reg <= (job_reg.mode == vse_pkg::MODE_RICH)
                            ? 64'(x_reg) * 64'(vse_pkg::RECIP_3)
                            : 64'(x_reg) * 64'(vse_pkg::RECIP_5);
            end
            BS_FIN: begin
                if (sval > 33'sh0_7FFF_FFFF)       curl_reg <= 32'h7FFF_FFFF;
                else if (sval < -33'sh0_8000_0000) curl_reg <= 32'h8000_0000;
                else                               curl_reg <= sval[31:0];
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/vorticity_stencil_engine_top.sv
// vorticity_stencil_engine_top: 2d curl of a raster velocity stream
// m_tvalid rises once an accepted beat has passed the front (window shift, job push), the
// queue and the back (mul, sum, div, fin); the front takes no new beat before the job push of
// the last one, which stalls while the queue is full, and the back takes one job at a time
// reset: synchronous active-low aresetn clears position, window, queue, states and configuration;
// line rams and datapath registers are not cleared
module vorticity_stencil_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // x_comp [15:0], y_comp [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // curl_value [31:0], cell_row [41:32], cell_col [51:42]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_wdata
);

    vse_pkg::cfg_t cfg_reg;
    vse_pkg::job_t push_job, head;
    logic job_push, pop, full, empty;
    logic [vse_pkg::CURL_W-1:0]  curl_value;
    logic [vse_pkg::COORD_W-1:0] cell_row, cell_col;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= vse_pkg::MODE_CENTRAL;
            cfg_reg.width  <= 11'd64;
            cfg_reg.height <= 11'd64;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                vse_pkg::REG_MODE:   cfg_reg.mode   <= cfg_wdata[vse_pkg::MODE_W-1:0];
                vse_pkg::REG_WIDTH:  cfg_reg.width  <= cfg_wdata;
                vse_pkg::REG_HEIGHT: cfg_reg.height <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vse_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .job_push   (job_push),
        .job        (push_job),
        .queue_full (full)
    );

    vse_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    vse_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (empty),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .curl_value  (curl_value),
        .cell_row    (cell_row),
        .cell_col    (cell_col)
    );

    // result beat packing
    assign m_tdata = {4'b0000, cell_col, cell_row, curl_value};

endmodule
